// ===== sv/vmr_pkg.sv =====
// Shared types and constants for the VU meter LED ring renderer.
// No dependencies; imported by every module of the block.
package vmr_pkg;

    localparam int LEVEL_W   = 15;
    localparam int PIX_W     = 6;
    localparam int POS_W     = 7;
    localparam int COLOR_W   = 8;
    localparam int CNT_W     = 14;
    localparam int CFG_IDX_W = 3;
    localparam int DIVD_W    = 30;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'd32767;
    localparam logic [15:0]        V_MAX      = 16'd65280;

    // channel = floor(floor(y / 256) / 65025), second step by reciprocal
    localparam int          CH_K     = 41;
    localparam logic [25:0] CH_RECIP = 26'(((64'd1 << CH_K) + 64'd65024) / 64'd65025);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_RED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_BLUE    = 3'd5;

    typedef struct packed {
        logic [COLOR_W-1:0] brightness;
        logic               reverse;
        logic [COLOR_W-1:0] start_green;
        logic [COLOR_W-1:0] start_blue;
        logic [COLOR_W-1:0] end_red;
        logic [COLOR_W-1:0] end_blue;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] m_l;
        logic [LEVEL_W-1:0] m_r;
    } level_pair_t;

endpackage

// ===== sv/vmr_div.sv =====
// Restoring divider, one quotient bit per cycle, 15-bit quotient.
// Depends on vmr_pkg. Caller guarantees dividend < divisor * 2^15.
module vmr_div
    import vmr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIVD_W-1:0]   dividend,
    input  logic [LEVEL_W-1:0]  divisor,
    output logic                done,
    output logic [LEVEL_W-1:0]  quotient
);

    logic [LEVEL_W-1:0] rem_reg, rem_next;
    logic [LEVEL_W-1:0] low_reg;
    logic [LEVEL_W-1:0] quo_reg;
    logic [LEVEL_W-1:0] den_reg;
    logic [3:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [LEVEL_W:0]   trial;
    logic               ge;

    always_comb
    begin
        trial    = {rem_reg, low_reg[LEVEL_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? LEVEL_W'(trial - {1'b0, den_reg}) : trial[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(LEVEL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[DIVD_W-1:LEVEL_W];
            low_reg <= dividend[LEVEL_W-1:0];
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[LEVEL_W-2:0], 1'b0};
            quo_reg <= {quo_reg[LEVEL_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/vmr_front.sv =====
// Front end: accepts level pairs, tracks peak and update count, scales levels.
// Depends on vmr_pkg and vmr_div.
module vmr_front
    import vmr_pkg::*;
#(
    parameter int RESET_PERIOD = 10000
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [LEVEL_W-1:0]  left_level,
    input  logic [LEVEL_W-1:0]  right_level,
    output logic                full,
    output logic                q_push,
    output level_pair_t         q_data,
    input  logic                q_full
);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_DIV_L = 4'b0010,
        F_DIV_R = 4'b0100,
        F_PUSH  = 4'b1000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic [LEVEL_W-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LEVEL_W-1:0] den_reg;
    logic [LEVEL_W-1:0] l_reg, r_reg;
    logic [LEVEL_W-1:0] ml_reg, mr_reg;
    logic               start_reg, start_next;
    logic               accept;
    logic [LEVEL_W-1:0] new_peak;
    logic [LEVEL_W-1:0] div_sel;
    logic [DIVD_W-1:0]  dividend;
    logic               div_done;
    logic [LEVEL_W-1:0] div_q;

    assign accept = push && (state_reg == F_IDLE);
    assign full   = (state_reg != F_IDLE);

    always_comb
    begin
        new_peak = peak_reg;
        if (left_level > new_peak)
            new_peak = left_level;
        if (right_level > new_peak)
            new_peak = right_level;
    end

    // level * 32767
    assign div_sel  = (state_reg == F_DIV_R) ? r_reg : l_reg;
    assign dividend = {div_sel, {LEVEL_W{1'b0}}} - DIVD_W'(div_sel);

    vmr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        peak_next  = peak_reg;
        count_next = count_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (32'(count_reg) + 32'd1 > 32'(RESET_PERIOD))
                    begin
                        count_next = '0;
                        peak_next  = '0;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        peak_next  = new_peak;
                    end
                    if (new_peak == '0)
                        state_next = F_PUSH;
                    else
                    begin
                        state_next = F_DIV_L;
                        start_next = 1'b1;
                    end
                end
            end
            F_DIV_L:
            begin
                if (div_done)
                begin
                    state_next = F_DIV_R;
                    start_next = 1'b1;
                end
            end
            F_DIV_R:
            begin
                if (div_done)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            start_reg <= 1'b0;
            peak_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            peak_reg  <= peak_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            l_reg   <= left_level;
            r_reg   <= right_level;
            den_reg <= new_peak;
            // zero peak: levels pass unscaled, and are zero
            ml_reg  <= left_level;
            mr_reg  <= right_level;
        end
        else if (div_done && state_reg == F_DIV_L)
            ml_reg <= div_q;
        else if (div_done && state_reg == F_DIV_R)
            mr_reg <= div_q;
    end

    assign q_data.m_l = ml_reg;
    assign q_data.m_r = mr_reg;

endmodule

// ===== sv/vmr_fifo.sv =====
// Two-entry queue of scaled level pairs between front and back end.
// Depends on vmr_pkg.
module vmr_fifo
    import vmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  level_pair_t wr_data,
    output logic        full,
    input  logic        rd_en,
    output level_pair_t rd_data,
    output logic        empty
);

    level_pair_t mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 2'd1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== sv/vmr_back.sv =====
// Back end: renders LED_COUNT pixels per level pair, left and right lanes
// side by side. Depends on vmr_pkg.
module vmr_back
    import vmr_pkg::*;
#(
    parameter int LED_COUNT = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                q_empty,
    input  level_pair_t         q_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [PIX_W-1:0]    pixel_index,
    output logic [COLOR_W-1:0]  red,
    output logic [COLOR_W-1:0]  green,
    output logic [COLOR_W-1:0]  blue,
    output logic                last
);

    localparam int          RECIP_K = 29;
    localparam logic [29:0] RECIP_N = 30'(((64'd1 << RECIP_K) + 64'(LED_COUNT) - 64'd1)
                                          / 64'(LED_COUNT));
    localparam int          RD_K    = 15;
    localparam logic [15:0] RECIP_D = 16'(((32'd1 << RD_K) + 32'(LED_COUNT) - 32'd1)
                                          / 32'(LED_COUNT));

    typedef enum logic [7:0] {
        B_IDLE  = 8'b00000001,
        B_NUM   = 8'b00000010,
        B_FOLD  = 8'b00000100,
        B_SCALE = 8'b00001000,
        B_BRT   = 8'b00010000,
        B_MUL   = 8'b00100000,
        B_DIV   = 8'b01000000,
        B_OUT   = 8'b10000000
    } bstate_t;

    bstate_t             state_reg, state_next;
    logic [PIX_W-1:0]    pix_reg;
    logic [LEVEL_W-1:0]  m_reg    [2];
    logic [POS_W-1:0]    p_reg    [2];
    logic                rise_reg [2];
    logic [20:0]         num_reg  [2];
    logic [21:0]         q1_reg   [2];
    logic [15:0]         v_reg    [2];
    logic [23:0]         bv_reg   [2];
    logic [COLOR_W-1:0]  comp_reg [2][3];
    logic [31:0]         y_reg    [2][3];
    logic [COLOR_W-1:0]  ch_reg   [2][3];
    logic signed [8:0]   d_reg    [3];

    logic [POS_W-1:0]    p_next    [2];
    logic                rise_next [2];
    logic [20:0]         num_next  [2];
    logic [21:0]         q1_next   [2];
    logic [15:0]         v_next    [2];
    logic [COLOR_W-1:0]  comp_next [2][3];
    logic [COLOR_W-1:0]  ch_next   [2][3];
    logic signed [8:0]   d_next    [3];
    logic [COLOR_W-1:0]  g_start   [3];
    logic [COLOR_W-1:0]  g_end     [3];
    logic [COLOR_W-1:0]  mix       [3];

    logic                out_valid_reg;
    logic [PIX_W-1:0]    pixel_index_reg;
    logic [COLOR_W-1:0]  color_reg [3];
    logic                last_reg;
    logic                out_free;
    logic                last_pix;

    assign out_free = !out_valid_reg || pop;
    assign last_pix = (pix_reg == PIX_W'(LED_COUNT - 1));
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    // gradient endpoints: red starts at 0, green ends at 0
    always_comb
    begin
        g_start[0] = '0;
        g_end[0]   = cfg.end_red;
        g_start[1] = cfg.start_green;
        g_end[1]   = '0;
        g_start[2] = cfg.start_blue;
        g_end[2]   = cfg.end_blue;
    end

    // per-color gradient step, truncated toward zero
    always_comb
    begin
        logic signed [9:0] diff;
        logic [7:0]        mag;
        logic [23:0]       prod;
        logic [7:0]        qd;
        for (int c = 0; c < 3; c++)
        begin
            diff      = $signed({2'b00, g_end[c]}) - $signed({2'b00, g_start[c]});
            mag       = diff[9] ? 8'(-diff) : diff[7:0];
            prod      = 24'(mag) * 24'(RECIP_D);
            qd        = prod[RD_K +: 8];
            d_next[c] = diff[9] ? -$signed({1'b0, qd}) : $signed({1'b0, qd});
        end
    end

    // ramp numerator per lane: lane 0 is left, lane 1 is right
    always_comb
    begin
        logic [21:0] nm, hi, lo;
        logic [23:0] fa, fb;
        for (int i = 0; i < 2; i++)
        begin
            p_next[i]    = (i == 0) ? POS_W'(LED_COUNT - 32'(pix_reg)) : POS_W'(pix_reg);
            nm           = 22'(32'(m_reg[i]) * 32'(LED_COUNT));
            hi           = 22'(32'(FULL_SCALE) * (32'(p_next[i]) + 32'd1));
            lo           = 22'(32'(FULL_SCALE) * 32'(p_next[i]));
            fa           = 24'(32'(FULL_SCALE)
                               * (32'd4 * 32'(p_next[i]) + 32'd4 + 32'(LED_COUNT)));
            fb           = {nm, 2'b00};
            rise_next[i] = nm < hi;
            if (rise_next[i])
                num_next[i] = (nm > lo) ? 21'(nm - lo) : '0;
            else
                num_next[i] = (fa > fb) ? 21'(fa - fb) : '0;
        end
    end

    // floor(num * 65280 / 32767) by folding 2^15 = 32767 + 1
    always_comb
    begin
        logic [36:0] x;
        logic [21:0] a;
        logic [22:0] r0;
        logic [15:0] r1;
        for (int i = 0; i < 2; i++)
        begin
            x          = 37'(num_reg[i]) * 37'(V_MAX);
            a          = x[36:15];
            r0         = 23'(a) + 23'(x[14:0]);
            r1         = 16'(r0[22:15]) + 16'(r0[14:0]);
            q1_next[i] = a + 22'(r0[22:15]) + 22'(r1 >= 16'(FULL_SCALE));
        end
    end

    // falling side still divides by LED_COUNT; gradient component at p
    always_comb
    begin
        logic [51:0]        prod;
        logic [21:0]        vf;
        logic signed [17:0] cs;
        for (int i = 0; i < 2; i++)
        begin
            prod = 52'(q1_reg[i]) * 52'(RECIP_N);
            vf   = rise_reg[i] ? q1_reg[i] : prod[RECIP_K +: 22];
            v_next[i] = (vf > 22'(V_MAX)) ? V_MAX : vf[15:0];
            for (int c = 0; c < 3; c++)
            begin
                cs = 18'(d_reg[c] * $signed({1'b0, p_reg[i]}))
                     + $signed({10'd0, g_start[c]});
                if (cs < 0)
                    comp_next[i][c] = '0;
                else if (cs > 18'sd255)
                    comp_next[i][c] = 8'd255;
                else
                    comp_next[i][c] = cs[7:0];
            end
        end
    end

    // channel = floor(y / 256 / 65025)
    always_comb
    begin
        logic [49:0] prod;
        logic [8:0]  r;
        for (int i = 0; i < 2; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod          = 50'(y_reg[i][c][31:8]) * 50'(CH_RECIP);
                r             = prod[CH_K +: 9];
                ch_next[i][c] = (r > 9'd255) ? 8'd255 : r[7:0];
            end
        end
    end

    // lane max; pixel zero is dark in reverse mode
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cfg.reverse && pix_reg == '0)
                mix[c] = '0;
            else
                mix[c] = (ch_reg[0][c] > ch_reg[1][c]) ? ch_reg[0][c] : ch_reg[1][c];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!q_empty) state_next = B_NUM;
            B_NUM:   state_next = B_FOLD;
            B_FOLD:  state_next = B_SCALE;
            B_SCALE: state_next = B_BRT;
            B_BRT:   state_next = B_MUL;
            B_MUL:   state_next = B_DIV;
            B_DIV:   state_next = B_OUT;
            B_OUT:
            begin
                if (out_free)
                    state_next = last_pix ? B_IDLE : B_NUM;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
                pix_reg <= '0;
            else if (state_reg == B_OUT && out_free && !last_pix)
                pix_reg <= pix_reg + PIX_W'(1);
            if (state_reg == B_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        if (q_pop)
        begin
            m_reg[0] <= q_data.m_l;
            m_reg[1] <= q_data.m_r;
        end
        if (state_reg == B_NUM)
        begin
            p_reg    <= p_next;
            rise_reg <= rise_next;
            num_reg  <= num_next;
        end
        if (state_reg == B_FOLD)
            q1_reg <= q1_next;
        if (state_reg == B_SCALE)
        begin
            v_reg    <= v_next;
            comp_reg <= comp_next;
        end
        if (state_reg == B_BRT)
        begin
            for (int i = 0; i < 2; i++)
                bv_reg[i] <= 24'(cfg.brightness) * 24'(v_reg[i]);
        end
        if (state_reg == B_MUL)
        begin
            for (int i = 0; i < 2; i++)
                for (int c = 0; c < 3; c++)
                    y_reg[i][c] <= 32'(bv_reg[i]) * 32'(comp_reg[i][c]);
        end
        if (state_reg == B_DIV)
            ch_reg <= ch_next;
        if (state_reg == B_OUT && out_free)
        begin
            pixel_index_reg <= pix_reg;
            color_reg       <= mix;
            last_reg        <= last_pix;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red         = color_reg[0];
    assign green       = color_reg[1];
    assign blue        = color_reg[2];
    assign last        = last_reg;

endmodule

// ===== sv/vu_meter_led_ring_renderer_top.sv =====
// Top level of the VU meter LED ring renderer: configuration registers,
// front end, level queue and pixel renderer. Depends on vmr_pkg and submodules.

// One push carries a left/right level pair; the block answers with LED_COUNT
// pixels (index, red, green, blue, last) in ring order. The front end folds the
// levels into the running peak and rescales both by 32767/peak with one
// shared divider, left level first, then right; no division is done when the
// peak is zero. It takes no new pair until the scaled pair is in the queue.
// A two-entry queue hands the scaled pair to the renderer, which steps each
// pixel through B_NUM, B_FOLD, B_SCALE, B_BRT, B_MUL, B_DIV and B_OUT (both
// channel lanes side by side) and takes the next pair only after the last
// pixel of the current one. Finished pixels wait in an output register, so
// the renderer stalls only when that register is still full. Configuration
// writes are always taken (ready stays high) and apply to items rendered
// afterwards; write only while the block is idle. Peak and update count
// clear after every RESET_PERIOD+1 updates.
module vu_meter_led_ring_renderer_top
    import vmr_pkg::*;
#(
    parameter int LED_COUNT    = 16,
    parameter int RESET_PERIOD = 10000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [LEVEL_W-1:0]    left_level,
    input  logic [LEVEL_W-1:0]    right_level,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      pixel_index,
    output logic [COLOR_W-1:0]    red,
    output logic [COLOR_W-1:0]    green,
    output logic [COLOR_W-1:0]    blue,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]    cfg_data
);

    cfg_t        cfg_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    level_pair_t q_wr_data;
    level_pair_t q_rd_data;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness  <= 8'd255;
            cfg_reg.reverse     <= 1'b0;
            cfg_reg.start_green <= 8'd255;
            cfg_reg.start_blue  <= 8'd0;
            cfg_reg.end_red     <= 8'd255;
            cfg_reg.end_blue    <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS:  cfg_reg.brightness  <= cfg_data;
                REG_REVERSE:     cfg_reg.reverse     <= cfg_data[0];
                REG_START_GREEN: cfg_reg.start_green <= cfg_data;
                REG_START_BLUE:  cfg_reg.start_blue  <= cfg_data;
                REG_END_RED:     cfg_reg.end_red     <= cfg_data;
                REG_END_BLUE:    cfg_reg.end_blue    <= cfg_data;
                default:         ;
            endcase
        end
    end

    vmr_front #(
        .RESET_PERIOD (RESET_PERIOD)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .left_level  (left_level),
        .right_level (right_level),
        .full        (full),
        .q_push      (q_push),
        .q_data      (q_wr_data),
        .q_full      (q_full)
    );

    vmr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    vmr_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last        (last)
    );

    // front never pushes into a full queue
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("level queue overflow");

    // front goes busy in the cycle after taking an item
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("front took an item without going busy");

    // last marks the final ring position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && last |-> pixel_index == PIX_W'(LED_COUNT - 1))
        else $error("last flag on wrong pixel");

    // in reverse mode pixel zero is dark
    a_rev_dark: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && cfg_reg.reverse && pixel_index == '0
            |-> red == '0 && green == '0 && blue == '0)
        else $error("pixel zero lit in reverse mode");

endmodule
